@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and off during rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER_AT_CLK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ hw/rtl/afd_pkg.sv @@
// ----------------------------------------------------------------------------
// afd_pkg
// Types and constants shared by the addressed frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAC_W       = 64;
  localparam int GAP_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = 3;
  localparam int PAY_BYTES   = 7;
  localparam int PAY_W       = PAY_BYTES * BYTE_W;
  localparam int POS_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = MAC_W;

  // Frame length limits; payload fields hold at most seven bytes
  localparam int MAX_LENGTH  = 10;
  localparam int MIN_LENGTH  = 4;
  localparam int FIELD_MAX   = 10;
  localparam int LEN_LIMIT   = (MAX_LENGTH < FIELD_MAX) ? MAX_LENGTH : FIELD_MAX;
  localparam int HDR_BYTES   = 3;

  localparam logic [GAP_W-1:0]  GAP_RESET = GAP_W'(70);
  localparam logic [BYTE_W-1:0] ALL_ONES  = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP = 2'd1;

  // Input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDR = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CSUM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_GAP  = 3'd4;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                broadcast;
    logic [BYTE_W-1:0]   command;
    logic [BYTE_W-1:0]   sequence_res;
    logic [CNT_W-1:0]    payload_count;
    logic [PAY_W-1:0]    payload;
  } result_t;

endpackage

@@ hw/rtl/addressed_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// addressed_frame_deframer_unit
// Deframes addressed command frames from received bytes and timing ticks.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | in_mode, in_rx_byte
//   out_    | output    | out_valid/out_ready| status, broadcast, command,
//           |           |                    | sequence_res, payload_count,
//           |           |                    | payload
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle unless the result register stalls: an item is
// registered on transfer, runs through the frame state machine once the
// result register has space and, if it ends a frame, lands in it.
// Synchronous active-low reset clears the frame state and both valid
// flags; gap_limit resets to 70. A stalled result register holds the
// frame core, and the input register then holds one further item.
// ----------------------------------------------------------------------------
module addressed_frame_deframer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [afd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [afd_pkg::BYTE_W-1:0]           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [afd_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_broadcast,
  output logic [afd_pkg::BYTE_W-1:0]           out_command,
  output logic [afd_pkg::BYTE_W-1:0]           out_sequence_res,
  output logic [afd_pkg::CNT_W-1:0]            out_payload_count,
  output logic [afd_pkg::PAY_W-1:0]            out_payload
);
  import afd_pkg::*;

  `include "assert_macros.svh"

  item_t   in_item;
  item_t   item;
  logic    item_v;
  logic    take;
  logic    space;
  logic    res_v;
  result_t res;
  result_t out_res;

  assign in_item.mode    = in_mode;
  assign in_item.rx_byte = in_rx_byte;

  // advance the core only when the result register can take a result
  assign take = item_v && space;

  afd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .item_v   (item_v),
    .item     (item)
  );

  afd_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (take),
    .item      (item),
    .res_v     (res_v),
    .res       (res)
  );

  afd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_v),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_broadcast     = out_res.broadcast;
  assign out_command       = out_res.command;
  assign out_sequence_res  = out_res.sequence_res;
  assign out_payload_count = out_res.payload_count;
  assign out_payload       = out_res.payload;

  `ASSERT_NEVER_AT_CLK(a_full_stall_blocks_input,
    item_v && out_valid && !out_ready && in_ready)
  `ASSERT_AT_CLK(a_status_in_range, out_valid |-> (out_status <= ST_GAP))
  `ASSERT_AT_CLK(a_bcast_not_on_mismatch,
    (out_valid && out_broadcast) |-> (out_status != ST_ADDR))
  `ASSERT_AT_CLK(a_count_only_after_len,
    (out_valid && out_payload_count != '0) |->
      (out_status == ST_OK || out_status == ST_CSUM || out_status == ST_GAP))

endmodule

@@ hw/rtl/afd_in_reg.sv @@
// ----------------------------------------------------------------------------
// afd_in_reg
// Input register: holds one accepted item until the frame core takes it.
// ----------------------------------------------------------------------------
module afd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  afd_pkg::item_t in_item,
  input  logic           take,
  output logic           item_v,
  output afd_pkg::item_t item
);
  import afd_pkg::*;

  logic  v_r;
  logic  v_nxt;
  item_t item_r;

  assign in_ready = !v_r || take;
  assign item_v   = v_r;
  assign item     = item_r;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (take) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ hw/rtl/afd_frame_core.sv @@
// ----------------------------------------------------------------------------
// afd_frame_core
// Frame state machine: address match, length check, field capture, checksum
// and gap timeout, one item per step.
// ----------------------------------------------------------------------------
module afd_frame_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [afd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              step,
  input  afd_pkg::item_t                    item,
  output logic                              res_v,
  output afd_pkg::result_t                  res
);
  import afd_pkg::*;

  localparam logic [2:0] PH_ADDR = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_SEQ  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;

  logic [MAC_W-1:0]  mac_r;
  logic [GAP_W-1:0]  gap_limit_r;

  logic [2:0]        phase_r,  phase_nxt;
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [CNT_W-1:0]  pc_r,     pc_nxt;
  logic [BYTE_W-1:0] sum_r,    sum_nxt;
  logic              own_r,    own_nxt;
  logic              all_r,    all_nxt;
  logic [BYTE_W-1:0] cmd_r,    cmd_nxt;
  logic [BYTE_W-1:0] seq_r,    seq_nxt;
  logic [PAY_W-1:0]  pay_r,    pay_nxt;
  logic [GAP_W-1:0]  gap_r,    gap_nxt;

  logic              fin;
  logic [STATUS_W-1:0] fin_status;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] mac_byte;
  logic [GAP_W-1:0]  gap_inc;
  logic [POS_W:0]    pos_inc;

  assign b        = item.rx_byte;
  // first address byte meets the top byte of the MAC
  assign mac_byte = mac_r[{~pos_r, 3'b000} +: BYTE_W];
  assign gap_inc  = gap_r + 1'b1;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    pc_nxt     = pc_r;
    sum_nxt    = sum_r;
    own_nxt    = own_r;
    all_nxt    = all_r;
    cmd_nxt    = cmd_r;
    seq_nxt    = seq_r;
    pay_nxt    = pay_r;
    gap_nxt    = gap_r;
    fin        = 1'b0;
    fin_status = ST_OK;

    if (item.mode == MODE_TICK) begin
      // ticks before the first byte of a frame are ignored
      if (!(phase_r == PH_ADDR && pos_r == '0)) begin
        gap_nxt = gap_inc;
        if (gap_inc == gap_limit_r) begin
          fin        = 1'b1;
          fin_status = ST_GAP;
        end
      end
    end else begin
      gap_nxt = '0;
      unique case (phase_r)
        PH_ADDR: begin
          own_nxt = own_r && (b == mac_byte);
          all_nxt = all_r && (b == ALL_ONES);
          sum_nxt = sum_r + b;
          pos_nxt = pos_inc[POS_W-1:0];
          if (pos_r == POS_W'(7)) begin
            if (!own_nxt && !all_nxt) begin
              fin        = 1'b1;
              fin_status = ST_ADDR;
            end else begin
              phase_nxt = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (b < BYTE_W'(MIN_LENGTH) || b > BYTE_W'(LEN_LIMIT)) begin
            fin        = 1'b1;
            fin_status = ST_LEN;
          end else begin
            pc_nxt    = CNT_W'(b - BYTE_W'(HDR_BYTES));
            sum_nxt   = sum_r + b;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = b;
          sum_nxt   = sum_r + b;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt   = b;
          sum_nxt   = sum_r + b;
          pos_nxt   = '0;
          phase_nxt = PH_PAY;
        end
        PH_PAY: begin
          for (int k = 0; k < PAY_BYTES; k++) begin
            if (pos_r == POS_W'(k)) begin
              pay_nxt[k*BYTE_W +: BYTE_W] = b;
            end
          end
          sum_nxt = sum_r + b;
          pos_nxt = pos_inc[POS_W-1:0];
          if (pos_inc >= {1'b0, pc_r}) begin
            phase_nxt = PH_SUM;
          end
        end
        default: begin
          fin        = 1'b1;
          fin_status = (b == sum_r) ? ST_OK : ST_CSUM;
        end
      endcase
    end

    // drop the frame context after any result
    if (fin) begin
      phase_nxt = PH_ADDR;
      pos_nxt   = '0;
      pc_nxt    = '0;
      sum_nxt   = '0;
      own_nxt   = 1'b1;
      all_nxt   = 1'b1;
      cmd_nxt   = '0;
      seq_nxt   = '0;
      pay_nxt   = '0;
      gap_nxt   = '0;
    end
  end

  always_comb begin
    res_v             = step && fin;
    res.status        = fin_status;
    res.broadcast     = (phase_r != PH_ADDR) && all_r && !own_r;
    res.command       = cmd_r;
    res.sequence_res  = seq_r;
    res.payload_count = pc_r;
    res.payload       = pay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r       <= '0;
      gap_limit_r <= GAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAC) begin
        mac_r <= cfg_wdata;
      end else if (cfg_index == CFG_GAP) begin
        gap_limit_r <= cfg_wdata[GAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      pos_r   <= '0;
      pc_r    <= '0;
      sum_r   <= '0;
      own_r   <= 1'b1;
      all_r   <= 1'b1;
      cmd_r   <= '0;
      seq_r   <= '0;
      pay_r   <= '0;
      gap_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      pc_r    <= pc_nxt;
      sum_r   <= sum_nxt;
      own_r   <= own_nxt;
      all_r   <= all_nxt;
      cmd_r   <= cmd_nxt;
      seq_r   <= seq_nxt;
      pay_r   <= pay_nxt;
      gap_r   <= gap_nxt;
    end
  end

endmodule

@@ hw/rtl/afd_out_reg.sv @@
// ----------------------------------------------------------------------------
// afd_out_reg
// Result register: holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module afd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  afd_pkg::result_t res,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output afd_pkg::result_t out_res
);
  import afd_pkg::*;

  logic    v_r;
  logic    v_nxt;
  result_t res_r;

  assign space     = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_res   = res_r;

  always_comb begin
    v_nxt = v_r;
    if (load) begin
      v_nxt = 1'b1;
    end else if (out_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
